[rtl/core/mcvm_pkg.sv]
package mcvm_pkg;

  // Raw MIDI value width (14-bit pitch bend covers 7-bit control change)
  localparam int RAW_W = 14;
  // Controllers 0..127 plus the pitch wheel
  localparam int NUM_CTRL = 129;
  localparam int CTRL_W = 8;
  localparam logic [CTRL_W-1:0] WHEEL_CTRL = 8'd128;
  localparam int TGT_W = 4;
  localparam int NUM_TARGETS = 16;
  localparam int PT_W = 16;
  // Count field wide enough for the largest breakpoint count allowed
  localparam int CNT_W = 7;

  localparam logic [3:0] ST_CC = 4'hB;
  localparam logic [3:0] ST_BEND = 4'hE;
  localparam logic [3:0] MSG_LEN = 4'd3;

  typedef enum logic [1:0] {
    OP_MIDI     = 2'd0,
    OP_WR_MAP   = 2'd1,
    OP_WR_POINT = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic [RAW_W-1:0] lo;
    logic [RAW_W-1:0] hi;
    logic [CNT_W-1:0] count;
  } map_entry_t;

endpackage

[rtl/core/mcvm_div.sv]
module mcvm_div import mcvm_pkg::*; #(
  parameter int DW = 20,
  parameter int VW = 14,
  parameter int SPS = 4,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [PW-1:0] in_payload,
  output logic [DW-1:0] out_quot,
  output logic [VW-1:0] out_rem,
  output logic [PW-1:0] out_payload
);

  localparam int NST = (DW + SPS - 1) / SPS;

  logic [VW-1:0] rem_q  [NST];
  logic [DW-1:0] work_q [NST];
  logic [VW-1:0] dvs_q  [NST];
  logic [PW-1:0] pay_q  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [VW-1:0] cur_rem;
    logic [DW-1:0] cur_work;
    logic [VW-1:0] cur_dvs;
    logic [PW-1:0] cur_pay;
    logic [VW-1:0] nxt_rem;
    logic [DW-1:0] nxt_work;

    if (s == 0) begin : g_in
      assign cur_rem  = '0;
      assign cur_work = in_dividend;
      assign cur_dvs  = in_divisor;
      assign cur_pay  = in_payload;
    end else begin : g_chain
      assign cur_rem  = rem_q[s-1];
      assign cur_work = work_q[s-1];
      assign cur_dvs  = dvs_q[s-1];
      assign cur_pay  = pay_q[s-1];
    end

    // Restoring steps: shift in one dividend bit, subtract where it fits
    always_comb begin
      logic [VW:0]   t;
      logic [VW-1:0] r;
      logic [DW-1:0] w;
      logic          qb;
      r = cur_rem;
      w = cur_work;
      t = '0;
      qb = 1'b0;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < DW) begin
          t = {r, w[DW-1]};
          if (t >= {1'b0, cur_dvs}) begin
            t = t - {1'b0, cur_dvs};
            qb = 1'b1;
          end else begin
            qb = 1'b0;
          end
          r = t[VW-1:0];
          w = {w[DW-2:0], qb};
        end
      end
      nxt_rem = r;
      nxt_work = w;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pay_q[s] <= '0;
      end else if (en) begin
        pay_q[s] <= cur_pay;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= nxt_rem;
        work_q[s] <= nxt_work;
        dvs_q[s]  <= cur_dvs;
      end
    end
  end

  assign out_quot    = work_q[NST-1];
  assign out_rem     = rem_q[NST-1];
  assign out_payload = pay_q[NST-1];

endmodule

[rtl/core/mcvm_map_store.sv]
module mcvm_map_store import mcvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              wr,
  input  logic [CTRL_W-1:0] wr_addr,
  input  map_entry_t        wr_data,
  input  logic [CTRL_W-1:0] rd_addr,
  output map_entry_t        rd_data
);

  map_entry_t           mem [NUM_CTRL];
  logic [NUM_CTRL-1:0]  valid;
  map_entry_t           rd_q;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr) begin
        valid[wr_addr] <= 1'b1;
      end
      if (en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  // An entry never written reads as unmapped
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

[rtl/core/mcvm_point_store.sv]
module mcvm_point_store import mcvm_pkg::*; #(
  parameter int IDXW = 4
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   wr,
  input  logic [CTRL_W+IDXW-1:0] wr_addr,
  input  logic [PT_W-1:0]        wr_data,
  input  logic [CTRL_W+IDXW-1:0] rd_addr_a,
  input  logic [CTRL_W+IDXW-1:0] rd_addr_b,
  output logic [PT_W-1:0]        rd_a,
  output logic [PT_W-1:0]        rd_b
);

  localparam int DEPTH = NUM_CTRL << IDXW;

  logic [PT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

endmodule

[rtl/core/midi_control_value_mapper.sv]
// Input to result: stage A (map read), B, segment divider, D (point reads), E, rounding
// divider, output register; dividers are pipelined restoring, 4 bits a stage. One beat per
// cycle unless the output stalls; every stage and both memory read ports advance together.
// Reset (rst, synchronous, active high) marks every controller unmapped through per-entry
// valid bits and empties the pipeline; the breakpoint store holds whatever was written.
module midi_control_value_mapper import mcvm_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata, lowest bit up: message_length[3:0], status_byte[11:4], data_first[18:12],
  // data_second[25:19], controller_index[33:26], target_id[37:34], range_low[51:38],
  // range_high[65:52], point_count[70:66], point_index[74:71], point_value[90:75]
  input  logic [95:0] s_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata, lowest bit up: target_id_out[3:0], mapped_value[19:4], source_controller[27:20]
  output logic [31:0] m_tdata
);

  localparam int IDXW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NUMW = RAW_W + IDXW;   // magnitude of (v - lo) * (count - 1)
  localparam int DV2W = 2 * RAW_W + 4;  // 2 * rem * |b - a| + |den|
  localparam int QW2  = PT_W + 2;       // interpolation step magnitude
  localparam logic signed [QW2:0] SAT_MAX = 19'sd32767;
  localparam logic signed [QW2:0] SAT_MIN = -19'sd32768;

  // Global advance: hold every stage while a result waits on the output
  logic en;
  logic accept;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------- input decode
  op_t               op;
  logic [3:0]        in_len;
  logic [7:0]        in_status;
  logic [6:0]        in_d1, in_d2;
  logic [CTRL_W-1:0] in_cidx;
  logic [TGT_W-1:0]  in_tgt;
  logic [RAW_W-1:0]  in_lo, in_hi;
  logic [4:0]        in_cnt;
  logic [3:0]        in_pidx;
  logic [PT_W-1:0]   in_pval;

  assign op        = op_t'(s_tuser);
  assign in_len    = s_tdata[3:0];
  assign in_status = s_tdata[11:4];
  assign in_d1     = s_tdata[18:12];
  assign in_d2     = s_tdata[25:19];
  assign in_cidx   = s_tdata[33:26];
  assign in_tgt    = s_tdata[37:34];
  assign in_lo     = s_tdata[51:38];
  assign in_hi     = s_tdata[65:52];
  assign in_cnt    = s_tdata[70:66];
  assign in_pidx   = s_tdata[74:71];
  assign in_pval   = s_tdata[90:75];

  logic              is_cc, is_bend, msg_ok;
  logic              map_wr, pt_wr;
  logic [CTRL_W-1:0] msg_ctrl;
  logic [RAW_W-1:0]  msg_v;
  logic              ctrl_ok;
  map_entry_t        map_wdata;

  assign is_cc   = in_status[7:4] == ST_CC;
  assign is_bend = in_status[7:4] == ST_BEND;
  assign ctrl_ok = in_cidx <= WHEEL_CTRL;

  always_comb begin
    msg_ok = 1'b0;
    map_wr = 1'b0;
    pt_wr  = 1'b0;
    unique case (op)
      OP_MIDI:     msg_ok = accept && in_len == MSG_LEN && (is_cc || is_bend);
      OP_WR_MAP:   map_wr = accept && ctrl_ok && 9'(in_tgt) < 9'(NUM_TARGETS);
      OP_WR_POINT: pt_wr  = accept && ctrl_ok && 7'(in_pidx) < 7'(MAX_POINTS);
      default: ;
    endcase
  end

  // Pitch bend is pseudo-controller 128 with the 14-bit value
  assign msg_ctrl = is_bend ? WHEEL_CTRL : {1'b0, in_d1};
  assign msg_v    = is_bend ? {in_d2, in_d1} : {7'd0, in_d2};

  always_comb begin
    map_wdata.target = in_tgt;
    map_wdata.lo     = in_lo;
    map_wdata.hi     = in_hi;
    // Clamp the count to the store depth
    map_wdata.count  = ({2'b00, in_cnt} > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                              : {2'b00, in_cnt};
  end

  // Mapping writes land at the edge that accepts them, so the read for any later message sees them
  map_entry_t map_rd;

  mcvm_map_store u_map (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .wr      (map_wr),
    .wr_addr (in_cidx),
    .wr_data (map_wdata),
    .rd_addr (msg_ctrl),
    .rd_data (map_rd)
  );

  // ---------------------------------------------------------------- stage A
  logic              a_msg, a_bpw;
  logic [CTRL_W-1:0] a_ctrl;
  logic [RAW_W-1:0]  a_v;
  logic [IDXW-1:0]   a_pidx;
  logic [PT_W-1:0]   a_pval;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_msg <= 1'b0;
      a_bpw <= 1'b0;
    end else if (en) begin
      a_msg <= msg_ok;
      a_bpw <= pt_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctrl <= pt_wr ? in_cidx : msg_ctrl;
      a_v    <= msg_v;
      a_pidx <= IDXW'(in_pidx);
      a_pval <= in_pval;
    end
  end

  // Place the value on the segment axis: num = (v - lo) * (count - 1), den = hi - lo
  logic                    a_go;
  logic [IDXW-1:0]         a_nm1;
  logic signed [RAW_W:0]   a_dnum, a_den;
  logic signed [NUMW:0]    a_num;
  logic                    a_vge;

  assign a_go   = a_msg && map_rd.count != '0;
  assign a_nm1  = IDXW'(map_rd.count - CNT_W'(1));
  assign a_dnum = $signed({1'b0, a_v}) - $signed({1'b0, map_rd.lo});
  assign a_den  = $signed({1'b0, map_rd.hi}) - $signed({1'b0, map_rd.lo});
  assign a_num  = a_dnum * $signed({1'b0, a_nm1});
  assign a_vge  = a_v >= map_rd.lo;

  // ---------------------------------------------------------------- stage B
  logic                  b_go, b_bpw;
  logic [CTRL_W-1:0]     b_ctrl;
  logic [IDXW-1:0]       b_pidx, b_nm1;
  logic [PT_W-1:0]       b_pval;
  logic signed [NUMW:0]  b_num;
  logic signed [RAW_W:0] b_den;
  logic                  b_vge;
  logic [TGT_W-1:0]      b_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_go  <= 1'b0;
      b_bpw <= 1'b0;
    end else if (en) begin
      b_go  <= a_go;
      b_bpw <= a_bpw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ctrl   <= a_ctrl;
      b_pidx   <= a_pidx;
      b_pval   <= a_pval;
      b_num    <= a_num;
      b_den    <= a_den;
      b_nm1    <= a_nm1;
      b_vge    <= a_vge;
      b_target <= map_rd.target;
    end
  end

  typedef struct packed {
    logic              go;
    logic              bpw;
    logic [CTRL_W-1:0] ctrl;
    logic [IDXW-1:0]   pidx;
    logic [PT_W-1:0]   pval;
    logic              num_neg;
    logic              den_neg;
    logic              den_zero;
    logic              vge;
    logic [IDXW-1:0]   nm1;
    logic [TGT_W-1:0]  target;
    logic [RAW_W-1:0]  aden;
  } seg_info_t;

  logic [NUMW-1:0]  b_anum;
  logic [RAW_W-1:0] b_aden;
  seg_info_t        b_info, c_info;
  logic [$bits(seg_info_t)-1:0] c_info_vec;
  logic [NUMW-1:0]  c_quot;
  logic [RAW_W-1:0] c_rem;

  // Divide magnitudes; the signs travel alongside
  assign b_anum = b_num[NUMW] ? NUMW'(-b_num) : b_num[NUMW-1:0];
  assign b_aden = b_den[RAW_W] ? RAW_W'(-b_den) : b_den[RAW_W-1:0];

  always_comb begin
    b_info.go       = b_go;
    b_info.bpw      = b_bpw;
    b_info.ctrl     = b_ctrl;
    b_info.pidx     = b_pidx;
    b_info.pval     = b_pval;
    b_info.num_neg  = b_num[NUMW];
    b_info.den_neg  = b_den[RAW_W];
    b_info.den_zero = b_den == '0;
    b_info.vge      = b_vge;
    b_info.nm1      = b_nm1;
    b_info.target   = b_target;
    b_info.aden     = b_aden;
  end

  mcvm_div #(
    .DW (NUMW),
    .VW (RAW_W),
    .PW ($bits(seg_info_t))
  ) u_seg_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_dividend (b_anum),
    .in_divisor  (b_aden),
    .in_payload  (b_info),
    .out_quot    (c_quot),
    .out_rem     (c_rem),
    .out_payload (c_info_vec)
  );

  assign c_info = seg_info_t'(c_info_vec);

  // ---------------------------------------------------------------- segment select
  // Truncated index i = +/- quotient; clamp to the end points or pick segment i
  logic            c_mix, c_direct;
  logic [IDXW-1:0] c_idx, c_idx1;
  logic [NUMW-1:0] c_nm1w;

  assign c_mix  = c_info.num_neg ^ c_info.den_neg;
  assign c_nm1w = NUMW'(c_info.nm1);

  always_comb begin
    c_direct = 1'b1;
    c_idx    = '0;
    priority if (c_info.den_zero) begin
      c_idx = c_info.vge ? c_info.nm1 : '0;
    end else if ((!c_mix || c_quot == '0) && c_quot >= c_nm1w) begin
      c_idx = c_info.nm1;
    end else if (c_mix && c_quot != '0) begin
      c_idx = '0;
    end else begin
      // Inside the range, or just below zero: interpolate from segment i
      c_direct = 1'b0;
      c_idx = c_quot[IDXW-1:0];
    end
  end

  assign c_idx1 = c_idx + IDXW'(1);

  // Breakpoint writes go in at this stage so they stay ordered with message reads
  logic [PT_W-1:0] pt_a, pt_b;

  mcvm_point_store #(
    .IDXW (IDXW)
  ) u_points (
    .clk       (clk),
    .en        (en),
    .wr        (en && c_info.bpw),
    .wr_addr   ({c_info.ctrl, c_info.pidx}),
    .wr_data   (c_info.pval),
    .rd_addr_a ({c_info.ctrl, c_idx}),
    .rd_addr_b ({c_info.ctrl, c_idx1}),
    .rd_a      (pt_a),
    .rd_b      (pt_b)
  );

  // ---------------------------------------------------------------- stage D
  logic              d_go, d_direct, d_mix;
  logic [RAW_W-1:0]  d_rem, d_aden;
  logic [TGT_W-1:0]  d_target;
  logic [CTRL_W-1:0] d_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_go <= 1'b0;
    end else if (en) begin
      d_go <= c_info.go;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_direct <= c_direct;
      d_mix    <= c_mix;
      d_rem    <= c_rem;
      d_aden   <= c_info.aden;
      d_target <= c_info.target;
      d_ctrl   <= c_info.ctrl;
    end
  end

  // Remainder times breakpoint step, magnitude and sign apart
  logic signed [PT_W:0]  d_diff;
  logic [PT_W-1:0]       d_adiff;
  logic [RAW_W+PT_W-1:0] d_prod;

  assign d_diff  = $signed({pt_b[PT_W-1], pt_b}) - $signed({pt_a[PT_W-1], pt_a});
  assign d_adiff = d_diff[PT_W] ? PT_W'(-d_diff) : d_diff[PT_W-1:0];
  assign d_prod  = d_rem * d_adiff;

  // ---------------------------------------------------------------- stage E
  logic                  e_go, e_direct, e_sign;
  logic [RAW_W+PT_W-1:0] e_prod;
  logic [RAW_W-1:0]      e_aden;
  logic [PT_W-1:0]       e_a;
  logic [TGT_W-1:0]      e_target;
  logic [CTRL_W-1:0]     e_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_go <= 1'b0;
    end else if (en) begin
      e_go <= d_go;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_direct <= d_direct;
      e_sign   <= d_mix ^ d_diff[PT_W];
      e_prod   <= d_prod;
      e_aden   <= d_aden;
      e_a      <= pt_a;
      e_target <= d_target;
      e_ctrl   <= d_ctrl;
    end
  end

  typedef struct packed {
    logic              go;
    logic              direct;
    logic              sign;
    logic [PT_W-1:0]   a;
    logic [TGT_W-1:0]  target;
    logic [CTRL_W-1:0] ctrl;
  } interp_info_t;

  // Round to nearest, ties away from zero: (2|p| + |den|) / (2|den|)
  logic [DV2W-1:0]  e_dvd;
  logic [RAW_W:0]   e_dvs;
  interp_info_t     e_info, f_info;
  logic [$bits(interp_info_t)-1:0] f_info_vec;
  logic [DV2W-1:0]  f_quot;
  logic [RAW_W:0]   f_rem;

  assign e_dvd = {1'b0, e_prod, 1'b0} + DV2W'(e_aden);
  assign e_dvs = {e_aden, 1'b0};

  always_comb begin
    e_info.go     = e_go;
    e_info.direct = e_direct;
    e_info.sign   = e_sign;
    e_info.a      = e_a;
    e_info.target = e_target;
    e_info.ctrl   = e_ctrl;
  end

  mcvm_div #(
    .DW (DV2W),
    .VW (RAW_W + 1),
    .PW ($bits(interp_info_t))
  ) u_round_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_dividend (e_dvd),
    .in_divisor  (e_dvs),
    .in_payload  (e_info),
    .out_quot    (f_quot),
    .out_rem     (f_rem),
    .out_payload (f_info_vec)
  );

  assign f_info = interp_info_t'(f_info_vec);

  // ---------------------------------------------------------------- final sum
  logic signed [QW2:0] f_step, f_sum;
  logic [PT_W-1:0]     f_sat, f_value;
  logic                f_unused;

  assign f_step = f_info.sign ? -$signed({1'b0, f_quot[QW2-1:0]})
                              : $signed({1'b0, f_quot[QW2-1:0]});
  assign f_sum  = $signed({{3{f_info.a[PT_W-1]}}, f_info.a}) + f_step;
  // The rounding remainder is not needed
  assign f_unused = ^f_rem;

  always_comb begin
    priority if (f_sum > SAT_MAX) begin
      f_sat = 16'h7FFF;
    end else if (f_sum < SAT_MIN) begin
      f_sat = 16'h8000;
    end else begin
      f_sat = f_sum[PT_W-1:0];
    end
  end

  assign f_value = f_info.direct ? f_info.a : f_sat;

  // ---------------------------------------------------------------- output beat
  logic [TGT_W-1:0]  out_target;
  logic [PT_W-1:0]   out_value;
  logic [CTRL_W-1:0] out_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= f_info.go;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_target <= f_info.target;
      out_value  <= f_value;
      out_ctrl   <= f_info.ctrl;
    end
  end

  assign m_tdata = {3'b000, f_unused & 1'b0, out_ctrl, out_value, out_target};

endmodule

[test/tb_mapper_checker.sv]
`timescale 1ns / 100ps
module tb_mapper_checker import mcvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          fail_count,
  output int          pending_updates,
  output int          update_count
);
  localparam int NPTS = 16;

  // Packed from the top bit down, so it lines up with m_tdata[27:0]
  typedef struct packed {
    logic [7:0]  ctrl;
    logic [15:0] value;
    logic [3:0]  tgt;
  } update_t;

  logic [3:0]  map_tgt [NUM_CTRL];
  int          map_lo [NUM_CTRL];
  int          map_hi [NUM_CTRL];
  int          map_cnt [NUM_CTRL];
  logic signed [15:0] points [NUM_CTRL][NPTS];
  update_t     expected_updates [$];

  function automatic longint round_quotient(longint p, longint q);
    longint ap, aq, t;
    ap = p < 0 ? -p : p;
    aq = q < 0 ? -q : q;
    t = (2 * ap + aq) / (2 * aq);
    return ((p < 0) != (q < 0)) ? -t : t;
  endfunction

  function automatic logic [15:0] interpolate(int c, int v);
    longint n, den, num, i, r, a, b, res;
    n = map_cnt[c];
    den = map_hi[c] - map_lo[c];
    num = (longint'(v) - map_lo[c]) * (n - 1);
    if (den == 0) return (v >= map_lo[c]) ? points[c][n-1] : points[c][0];
    i = num / den;
    if (i >= n - 1) return points[c][n-1];
    if (i < 0) return points[c][0];
    r = num - i * den;
    a = points[c][i];
    b = points[c][i+1];
    res = a + round_quotient(r * (b - a), den);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  always @(posedge clk) begin
    int c, v, pi;
    update_t got, exp_u;
    if (rst) begin
      for (int k = 0; k < NUM_CTRL; k++) map_cnt[k] = 0;
      expected_updates.delete();
      fail_count = 0;
      update_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        c = int'(s_tdata[33:26]);
        pi = int'(s_tdata[74:71]);
        case (s_tuser)
          OP_WR_MAP: if (c < NUM_CTRL && int'(s_tdata[37:34]) < NUM_TARGETS) begin
            map_tgt[c] = s_tdata[37:34];
            map_lo[c] = int'(s_tdata[51:38]);
            map_hi[c] = int'(s_tdata[65:52]);
            map_cnt[c] = (int'(s_tdata[70:66]) > NPTS) ? NPTS : int'(s_tdata[70:66]);
          end
          OP_WR_POINT: if (c < NUM_CTRL && pi < NPTS) points[c][pi] = s_tdata[90:75];
          OP_MIDI: if (s_tdata[3:0] == MSG_LEN) begin
            c = -1;
            v = 0;
            if (s_tdata[11:8] == ST_CC) begin
              c = int'(s_tdata[18:12]);
              v = int'(s_tdata[25:19]);
            end else if (s_tdata[11:8] == ST_BEND) begin
              c = int'(WHEEL_CTRL);
              v = (int'(s_tdata[25:19]) << 7) + int'(s_tdata[18:12]);
            end
            if (c >= 0 && map_cnt[c] != 0) begin
              exp_u.tgt = map_tgt[c];
              exp_u.value = interpolate(c, v);
              exp_u.ctrl = c[7:0];
              expected_updates = {expected_updates, exp_u};
            end
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[27:0];
        update_count++;
        if (expected_updates.size() == 0) begin
          $error("unexpected update beat %h", m_tdata);
          fail_count++;
        end else begin
          exp_u = expected_updates.pop_front();
          if (got.tgt != exp_u.tgt) begin
            $error("target_id_out expected %0d actual %0d", exp_u.tgt, got.tgt);
            fail_count++;
          end
          if (got.value != exp_u.value) begin
            $error("mapped_value expected %0d actual %0d",
                   $signed(exp_u.value), $signed(got.value));
            fail_count++;
          end
          if (got.ctrl != exp_u.ctrl) begin
            $error("source_controller expected %0d actual %0d", exp_u.ctrl, got.ctrl);
            fail_count++;
          end
        end
      end
    end
    pending_updates = expected_updates.size();
  end
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
module tb_top import mcvm_pkg::*;;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk, rst;
  logic        s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic [31:0] m_tdata;
  int          fail_count, pending_updates, update_count, cycles = 0;
  int          gap_left = 0, burst_left = 0;
  // Controllers whose breakpoints 0..15 have all been written; map_random maps only these
  bit          primed [NUM_CTRL];

  midi_control_value_mapper dut (.*);

  tb_mapper_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver: stall pattern of its own, with quiet stretches of full acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ((cycles / 600) % 3 == 0) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [95:0] pack(int len, int st, int d1, int d2, int ci,
                                       int tg, int lo, int hi, int cnt, int pi, int pv);
    logic [95:0] d;
    d = '0;
    d[3:0] = 4'(len); d[11:4] = 8'(st); d[18:12] = 7'(d1); d[25:19] = 7'(d2);
    d[33:26] = 8'(ci); d[37:34] = 4'(tg); d[51:38] = 14'(lo); d[65:52] = 14'(hi);
    d[70:66] = 5'(cnt); d[74:71] = 4'(pi); d[90:75] = 16'(pv);
    return d;
  endfunction

  // Send one beat, holding it until accepted; bursts with random gaps between
  task automatic send(logic [1:0] op, logic [95:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_left > 0) s_tvalid <= 1'b0;
    end
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic prime_points(int c);
    for (int k = 0; k < 16; k++)
      send(OP_WR_POINT, pack(0, 0, 0, 0, c, 0, 0, 0, 0, k, $urandom_range(0, 65535)));
    primed[c] = 1;
  endtask

  task automatic map_random(int c);
    int lo;
    lo = $urandom_range(0, 16383);
    case ($urandom_range(0, 4))
      0: send(OP_WR_MAP, pack(0, 0, 0, 0, c, $urandom_range(0, 15), lo, lo,
                              $urandom_range(1, 31), 0, 0));
      1: send(OP_WR_MAP, pack(0, 0, 0, 0, c, $urandom_range(0, 15),
                              $urandom_range(0, 127), $urandom_range(0, 127),
                              $urandom_range(1, 31), 0, 0));
      default: send(OP_WR_MAP, pack(0, 0, 0, 0, c, $urandom_range(0, 15), lo,
                                    $urandom_range(0, 16383), $urandom_range(0, 17), 0, 0));
    endcase
  endtask

  task automatic midi_random(int c);
    int d2;
    d2 = $urandom_range(0, 127);
    if (c == WHEEL_CTRL)
      send(OP_MIDI, pack(3, {ST_BEND, 4'($urandom)}, $urandom_range(0, 127), d2,
                         $urandom_range(0, 255), 0, 0, 0, 0, 0, 0));
    else
      send(OP_MIDI, pack(3, {ST_CC, 4'($urandom)}, c, d2, $urandom_range(0, 255),
                         0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    int c, m;
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: two primed controllers, edge ranges, counts and ignored writes
    prime_points(5);
    prime_points(WHEEL_CTRL);
    send(OP_WR_MAP, pack(0, 0, 0, 0, 5, 15, 0, 127, 16, 0, 0));
    send(OP_MIDI, pack(3, 8'hB0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    send(OP_MIDI, pack(3, 8'hBF, 5, 127, 0, 0, 0, 0, 0, 0, 0));
    send(OP_MIDI, pack(2, 8'hB0, 5, 64, 0, 0, 0, 0, 0, 0, 0));
    send(OP_MIDI, pack(3, 8'h90, 5, 64, 0, 0, 0, 0, 0, 0, 0));
    send(OP_WR_MAP, pack(0, 0, 0, 0, WHEEL_CTRL, 3, 16383, 0, 31, 0, 0));
    send(OP_MIDI, pack(3, 8'hE0, 127, 127, 0, 0, 0, 0, 0, 0, 0));
    send(OP_MIDI, pack(3, 8'hE3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(OP_WR_MAP, pack(0, 0, 0, 0, 5, 1, 100, 100, 1, 0, 0));
    send(OP_MIDI, pack(3, 8'hB0, 5, 99, 0, 0, 0, 0, 0, 0, 0));
    send(OP_WR_MAP, pack(0, 0, 0, 0, 5, 1, 100, 100, 2, 0, 0));
    send(OP_MIDI, pack(3, 8'hB0, 5, 100, 0, 0, 0, 0, 0, 0, 0));
    send(OP_MIDI, pack(3, 8'hB0, 5, 50, 0, 0, 0, 0, 0, 0, 0));
    send(OP_WR_MAP, pack(0, 0, 0, 0, 5, 2, 120, 10, 16, 0, 0));
    send(OP_MIDI, pack(3, 8'hB0, 5, 127, 0, 0, 0, 0, 0, 0, 0));
    send(OP_MIDI, pack(3, 8'hB0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    send(OP_WR_POINT, pack(0, 0, 0, 0, 200, 0, 0, 0, 0, 3, 16'h8000));
    send(OP_RESERVED, '1);
    send(OP_WR_MAP, pack(0, 0, 0, 0, 5, 0, 0, 0, 0, 0, 0));
    send(OP_MIDI, pack(3, 8'hB0, 5, 9, 0, 0, 0, 0, 0, 0, 0));

    // Random: mostly mapped traffic with random maps, some noise
    for (int n = 0; n < 1000; n++) begin
      c = ($urandom_range(0, 5) == 0) ? WHEEL_CTRL : $urandom_range(0, 11);
      m = $urandom_range(0, 19);
      if (!primed[c]) prime_points(c);
      else if (m < 2) map_random(c);
      else if (m < 4) send(OP_WR_POINT, pack(0, 0, 0, 0, $urandom_range(0, 255), 0, 0, 0,
                                             0, $urandom_range(0, 15),
                                             $urandom_range(0, 65535)));
      else if (m < 5) send(2'($urandom), {$urandom, $urandom, $urandom} & ~96'h0 &
                           {32'h0, 64'hFFFF_FFFF_FFFF_FFFF} | {8'h0, 4'h0, $urandom});
      else midi_random(c);
    end
    s_tvalid <= 1'b0;

    while (pending_updates != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d updates over CC and pitch-bend, with map rewrites, unmaps,",
             update_count);
    $display("equal and inverted ranges, ignored writes and random flow control.");
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

[files.f]
rtl/core/mcvm_pkg.sv
rtl/core/mcvm_div.sv
rtl/core/mcvm_map_store.sv
rtl/core/mcvm_point_store.sv
rtl/core/midi_control_value_mapper.sv
test/tb_mapper_checker.sv
test/tb_top.sv
